// ===== rtl/spq_pkg.sv =====
// Package for the stable priority run queue: sizes, command and status codes,
// and the entry and command types shared by the cells and the top level.
// No dependencies.
package spq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam int KIND_W  = 2;
   localparam int TAG_W   = 64;
   localparam int LABEL_W = 64;
   localparam int RANK_W  = 16;
   localparam int STAT_W  = 2;
   localparam int OCC_W   = 7;

   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_POP    = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [LABEL_W-1:0] label;
      logic [RANK_W-1:0]  rank;
   } entry_type;

   // broadcast to every cell in the chain
   typedef struct packed {
      logic      insert;
      logic      pop;
      entry_type entry;
   } cmd_type;

endpackage

// ===== rtl/spq_if.sv =====
// Valid/ready channel interfaces for the request and response sides of the
// stable priority run queue. Depends on spq_pkg.
interface spq_req_if;
   import spq_pkg::*;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [TAG_W-1:0]    proc_tag;
   logic [LABEL_W-1:0]  proc_label;
   logic [RANK_W-1:0]   rank;

   modport source (output valid, output kind, output proc_tag, output proc_label,
                   output rank, input ready);
   modport sink   (input valid, input kind, input proc_tag, input proc_label,
                   input rank, output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;
   logic                valid;
   logic                ready;
   logic [STAT_W-1:0]   status;
   logic [TAG_W-1:0]    out_tag;
   logic [LABEL_W-1:0]  out_label;
   logic [RANK_W-1:0]   out_rank;
   logic [OCC_W-1:0]    occupancy;

   modport source (output valid, output status, output out_tag, output out_label,
                   output out_rank, output occupancy, input ready);
   modport sink   (input valid, input status, input out_tag, input out_label,
                   input out_rank, input occupancy, output ready);
endinterface

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, compares it with the incoming
// rank and shifts with its neighbours. Depends on spq_pkg.
module spq_cell (
   input  logic               clock,
   input  spq_pkg::cmd_type   cmd,
   input  logic               occupied,
   input  logic               left_place,
   input  spq_pkg::entry_type left_entry,
   input  spq_pkg::entry_type right_entry,
   output logic               place,
   output spq_pkg::entry_type entry
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // strictly greater keeps equal ranks in arrival order
   assign place = !occupied || (entry_ff.rank > cmd.entry.rank);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.pop) begin
         entry_in = right_entry;
      end else if (cmd.insert && place) begin
         entry_in = left_place ? left_entry : cmd.entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== rtl/stable_priority_run_queue_top.sv =====
// Top level of the stable priority run queue: a chain of sorting cells, the
// fill count and the registered response. Depends on spq_pkg, spq_if, spq_cell.
//
// The queue holds up to QUEUE_DEPTH entries in a row of cells kept sorted by
// rank, smallest first, with equal ranks in arrival order. Each request is a
// clear, an insert or a pop, and gives exactly one response carrying status
// (ok, empty, full), the popped entry (zero unless a pop succeeded) and the
// occupancy after the request. A request is taken in every cycle in which the
// response register is empty or its response is being taken, so one request
// per cycle is sustained; its response appears on the following cycle. The
// rate is set by the cells: every cell compares its rank with the incoming one
// in parallel and all of them shift in the same cycle, whatever the fill. No
// clearing pass is needed after reset; only the fill count and response valid
// flag are reset, and slots beyond the fill count are never read.
module stable_priority_run_queue_top (
   input  logic        clock,
   input  logic        reset,
   spq_req_if.sink     req_bus,
   spq_rsp_if.source   rsp_bus
);
   import spq_pkg::*;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [STAT_W-1:0]  rsp_status_ff;
   logic [STAT_W-1:0]  rsp_status_in;
   entry_type          rsp_entry_ff;
   entry_type          rsp_entry_in;

   logic               full;
   logic               empty;
   logic               transfer;
   cmd_type            cmd;

   entry_type          cell_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_place;
   logic [QUEUE_DEPTH-1:0] cell_occupied;

   assign full     = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);

   // output register parts the two sides: take a request while it is empty or
   // the held response is leaving
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign transfer      = req_bus.valid && req_bus.ready;

   assign cmd.insert      = transfer && (req_bus.kind == KIND_INSERT) && !full;
   assign cmd.pop         = transfer && (req_bus.kind == KIND_POP) && !empty;
   assign cmd.entry.tag   = req_bus.proc_tag;
   assign cmd.entry.label = req_bus.proc_label;
   assign cmd.entry.rank  = req_bus.rank;

   // chain of cells; slot 0 is the front
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      localparam logic [COUNT_W-1:0] SLOT = COUNT_W'(i);
      logic      left_place;
      entry_type left_entry;
      entry_type right_entry;

      assign cell_occupied[i] = (SLOT < count_ff);

      if (i == 0) begin : g_front
         assign left_place = 1'b0;
         assign left_entry = cmd.entry;
      end else begin : g_inner
         assign left_place = cell_place[i-1];
         assign left_entry = cell_entry[i-1];
      end

      // last slot falls out of the occupied range on a pop, so its fill is moot
      if (i == QUEUE_DEPTH - 1) begin : g_back
         assign right_entry = cmd.entry;
      end else begin : g_mid
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (cell_occupied[i]),
         .left_place  (left_place),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .place       (cell_place[i]),
         .entry       (cell_entry[i])
      );
   end

   // fill count and response
   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;

      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (transfer) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_OK;
         rsp_entry_in  = '0;
         case (req_bus.kind)
            KIND_CLEAR: begin
               count_in = '0;
            end
            KIND_INSERT: begin
               if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  count_in = count_ff + COUNT_W'(1);
               end
            end
            KIND_POP: begin
               if (empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_entry_in = cell_entry[0];
                  count_in     = count_ff - COUNT_W'(1);
               end
            end
            default: begin
               // meaningless kind: queue untouched, plain ok
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   logic [OCC_W-1:0] occ_ff;
   logic [OCC_W-1:0] occ_in;

   assign occ_in = transfer ? OCC_W'(count_in) : occ_ff;

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      occ_ff        <= occ_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.out_tag   = rsp_entry_ff.tag;
   assign rsp_bus.out_label = rsp_entry_ff.label;
   assign rsp_bus.out_rank  = rsp_entry_ff.rank;
   assign rsp_bus.occupancy = occ_ff;

endmodule
